@@ hdl/tesp_pkg.sv @@
// Shared types and byte codes for the terminal escape sequence parser.
package tesp_pkg;

   // Payload counter width; every buffer cap fits below 64
   localparam int CNT_W = 6;

   // Byte codes recognized by the parser
   localparam logic [7:0] BYTE_BEL       = 8'h07;
   localparam logic [7:0] BYTE_CAN       = 8'h18;
   localparam logic [7:0] BYTE_SUB       = 8'h1A;
   localparam logic [7:0] BYTE_ESC       = 8'h1B;
   localparam logic [7:0] BYTE_SPACE     = 8'h20;
   localparam logic [7:0] BYTE_FINAL_LO  = 8'h40;
   localparam logic [7:0] BYTE_FINAL_HI  = 8'h7E;
   localparam logic [7:0] BYTE_DCS_INTRO = 8'h50;   // 'P'
   localparam logic [7:0] BYTE_CSI_INTRO = 8'h5B;   // '['
   localparam logic [7:0] BYTE_ST_TAIL   = 8'h5C;   // backslash
   localparam logic [7:0] BYTE_OSC_INTRO = 8'h5D;   // ']'

   typedef enum logic [3:0] {
      ST_GROUND      = 4'd0,
      ST_ESC         = 4'd1,
      ST_CSI         = 4'd2,
      ST_OSC         = 4'd3,
      ST_OSC_ESC     = 4'd4,
      ST_DCS         = 4'd5,
      ST_DCS_ESC     = 4'd6,
      ST_DCS_IGN     = 4'd7,
      ST_DCS_IGN_ESC = 4'd8
   } parse_state_type;

   typedef enum logic {
      PH_RUN   = 1'b0,
      PH_DRAIN = 1'b1
   } phase_type;

   typedef enum logic [3:0] {
      EV_TEXT      = 4'd0,
      EV_CONTROL   = 4'd1,
      EV_ESC_FINAL = 4'd2,
      EV_CSI_PARAM = 4'd3,
      EV_CSI_FINAL = 4'd4,
      EV_OSC_BYTE  = 4'd5,
      EV_OSC_END   = 4'd6,
      EV_DCS_BYTE  = 4'd7,
      EV_DCS_END   = 4'd8
   } event_kind_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic           push;         // store the input byte at the fill count
      logic           cnt_clear;    // drop the buffered payload
      logic           emit;         // load one event carrying the input byte
      event_kind_type emit_kind;
      logic           drain_start;  // begin replaying the payload
      logic           drain_run;    // drain in progress
      event_kind_type dr_kind;      // kind of each replayed payload byte
      event_kind_type fin_kind;     // closing event kind
      logic           fin_use_byte; // closing event carries the input byte
      logic           ext;          // escape-final event follows the close
   } tesp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic             out_free;   // output register can take an event
      logic [CNT_W-1:0] count;      // bytes held in the payload store
      logic             drain_done; // last event of a drain loaded
   } tesp_sts_type;

endpackage

@@ hdl/tesp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tesp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tesp_ctrl.sv @@
// Parse state machine: decodes each byte into datapath commands.
module tesp_ctrl #(
   parameter int CSI_CAP = 32,
   parameter int OSC_CAP = 48,
   parameter int DCS_CAP = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            in_byte,
   input  tesp_pkg::tesp_sts_type sts,
   output tesp_pkg::tesp_cmd_type cmd
);
   import tesp_pkg::*;

   parse_state_type state_ff, state_in;
   phase_type       phase_ff, phase_in;
   logic            accept;
   logic            intro;
   logic            can_sub;
   logic            csi_full, osc_full, dcs_full;

   // byte classes
   assign intro   = (in_byte == BYTE_CSI_INTRO) || (in_byte == BYTE_OSC_INTRO) ||
                    (in_byte == BYTE_DCS_INTRO);
   assign can_sub = (in_byte == BYTE_CAN) || (in_byte == BYTE_SUB);

   assign csi_full = sts.count >= CNT_W'(CSI_CAP);
   assign osc_full = sts.count >= CNT_W'(OSC_CAP);
   assign dcs_full = sts.count >= CNT_W'(DCS_CAP);

   // take bytes only outside a drain and when the output can hold an event
   assign req_ready = (phase_ff == PH_RUN) && sts.out_free;
   assign accept    = req_valid && req_ready;

   // state after an escape introducer
   function automatic parse_state_type esc_next(input logic [7:0] b);
      parse_state_type s;
      if (b == BYTE_CSI_INTRO) begin
         s = ST_CSI;
      end else if (b == BYTE_OSC_INTRO) begin
         s = ST_OSC;
      end else if (b == BYTE_DCS_INTRO) begin
         s = ST_DCS;
      end else begin
         s = ST_GROUND;
      end
      return s;
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_RUN: begin
            if (accept && cmd.drain_start) begin
               phase_in = PH_DRAIN;
            end
         end
         PH_DRAIN: begin
            if (sts.drain_done) begin
               phase_in = PH_RUN;
            end
         end
         default: phase_in = PH_RUN;
      endcase
      if (accept) begin
         unique case (state_ff)
            ST_ESC: state_in = esc_next(in_byte);
            ST_CSI: begin
               if (in_byte >= BYTE_FINAL_LO && in_byte <= BYTE_FINAL_HI) begin
                  state_in = ST_GROUND;
               end else if (csi_full) begin
                  state_in = ST_GROUND;
               end
            end
            ST_OSC: begin
               if (in_byte == BYTE_BEL) begin
                  state_in = ST_GROUND;
               end else if (in_byte == BYTE_ESC) begin
                  state_in = ST_OSC_ESC;
               end else if (osc_full) begin
                  state_in = ST_GROUND;
               end
            end
            ST_OSC_ESC: begin
               state_in = (in_byte == BYTE_ST_TAIL) ? ST_GROUND : esc_next(in_byte);
            end
            ST_DCS: begin
               if (in_byte == BYTE_ESC) begin
                  state_in = ST_DCS_ESC;
               end else if (can_sub) begin
                  state_in = ST_GROUND;
               end else if (dcs_full) begin
                  state_in = ST_DCS_IGN;
               end
            end
            ST_DCS_ESC: begin
               state_in = (in_byte == BYTE_ST_TAIL) ? ST_GROUND : esc_next(in_byte);
            end
            ST_DCS_IGN: begin
               if (in_byte == BYTE_ESC) begin
                  state_in = ST_DCS_IGN_ESC;
               end else if (can_sub) begin
                  state_in = ST_GROUND;
               end
            end
            ST_DCS_IGN_ESC: begin
               if (in_byte == BYTE_ST_TAIL) begin
                  state_in = ST_GROUND;
               end else if (in_byte != BYTE_ESC) begin
                  state_in = ST_DCS_IGN;
               end
            end
            // ground, and any unused code
            default: state_in = (in_byte == BYTE_ESC) ? ST_ESC : ST_GROUND;
         endcase
      end
   end

   // command outputs
   always_comb begin
      cmd              = '0;
      cmd.emit_kind    = EV_TEXT;
      cmd.dr_kind      = EV_CSI_PARAM;
      cmd.fin_kind     = EV_CSI_FINAL;
      cmd.drain_run    = (phase_ff == PH_DRAIN);
      if (accept) begin
         unique case (state_ff)
            ST_ESC: begin
               cmd.cnt_clear = 1'b1;
               cmd.emit      = !intro;
               cmd.emit_kind = EV_ESC_FINAL;
            end
            ST_CSI: begin
               if (in_byte >= BYTE_FINAL_LO && in_byte <= BYTE_FINAL_HI) begin
                  cmd.drain_start  = 1'b1;
                  cmd.dr_kind      = EV_CSI_PARAM;
                  cmd.fin_kind     = EV_CSI_FINAL;
                  cmd.fin_use_byte = 1'b1;
               end else if (csi_full) begin
                  cmd.cnt_clear = 1'b1;
               end else begin
                  cmd.push = 1'b1;
               end
            end
            ST_OSC: begin
               if (in_byte == BYTE_BEL) begin
                  cmd.drain_start = 1'b1;
                  cmd.dr_kind     = EV_OSC_BYTE;
                  cmd.fin_kind    = EV_OSC_END;
               end else if (in_byte == BYTE_ESC) begin
                  cmd.push = 1'b0;
               end else if (osc_full) begin
                  cmd.cnt_clear = 1'b1;
               end else begin
                  cmd.push = 1'b1;
               end
            end
            ST_OSC_ESC: begin
               // any byte closes the OSC; a non-terminator that opens no new sequence is then an escape byte
               cmd.drain_start = 1'b1;
               cmd.dr_kind     = EV_OSC_BYTE;
               cmd.fin_kind    = EV_OSC_END;
               cmd.ext         = (in_byte != BYTE_ST_TAIL) && !intro;
            end
            ST_DCS: begin
               if (in_byte == BYTE_ESC) begin
                  cmd.push = 1'b0;
               end else if (can_sub || dcs_full) begin
                  cmd.cnt_clear = 1'b1;
               end else begin
                  cmd.push = 1'b1;
               end
            end
            ST_DCS_ESC: begin
               if (in_byte == BYTE_ST_TAIL) begin
                  cmd.drain_start = 1'b1;
                  cmd.dr_kind     = EV_DCS_BYTE;
                  cmd.fin_kind    = EV_DCS_END;
               end else begin
                  cmd.cnt_clear = 1'b1;
                  cmd.emit      = !intro;
                  cmd.emit_kind = EV_ESC_FINAL;
               end
            end
            ST_DCS_IGN, ST_DCS_IGN_ESC: begin
               cmd.push = 1'b0;
            end
            default: begin
               if (in_byte != BYTE_ESC) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = (in_byte < BYTE_SPACE) ? EV_CONTROL : EV_TEXT;
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_GROUND;
         phase_ff <= PH_RUN;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ hdl/tesp_dpath.sv @@
// Datapath: payload store, fill count, drain sequencer and output register.
module tesp_dpath #(
   parameter int DEPTH = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             in_byte,
   input  tesp_pkg::tesp_cmd_type  cmd,
   output tesp_pkg::tesp_sts_type  sts,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_event_kind,
   output logic [7:0]             rsp_event_byte,
   output logic                   rsp_last_of_run
);
   import tesp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             pend_ff, pend_in;
   logic             fin_pend_ff, fin_pend_in;
   logic             ext_pend_ff, ext_pend_in;
   event_kind_type   dr_kind_ff, dr_kind_in;
   event_kind_type   fin_kind_ff, fin_kind_in;
   logic [7:0]       fin_byte_ff, fin_byte_in;
   logic [7:0]       ext_byte_ff, ext_byte_in;
   logic             rsp_valid_ff, rsp_valid_in;
   event_kind_type   rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             rd_en;
   logic [7:0]       rd_data;
   logic             pay_load, fin_load, ext_load, drain_done;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // payload store
   tesp_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (in_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // drain sequencing: payload bytes, then close event, then optional escape final
   assign pay_load   = cmd.drain_run && pend_ff && out_free;
   assign rd_en      = cmd.drain_run && (rd_ptr_ff < count_ff) && (!pend_ff || pay_load);
   assign fin_load   = cmd.drain_run && !pend_ff && (rd_ptr_ff == count_ff) &&
                       fin_pend_ff && out_free;
   assign ext_load   = cmd.drain_run && !fin_pend_ff && ext_pend_ff && out_free;
   assign drain_done = (fin_load && !ext_pend_ff) || ext_load;

   always_comb begin
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      pend_in     = pend_ff;
      fin_pend_in = fin_pend_ff;
      ext_pend_in = ext_pend_ff;
      dr_kind_in  = dr_kind_ff;
      fin_kind_in = fin_kind_ff;
      fin_byte_in = fin_byte_ff;
      ext_byte_in = ext_byte_ff;

      // fill count
      if (cmd.cnt_clear || drain_done) begin
         count_in = '0;
      end else if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end

      // drain setup
      if (cmd.drain_start) begin
         rd_ptr_in   = '0;
         pend_in     = 1'b0;
         fin_pend_in = 1'b1;
         ext_pend_in = cmd.ext;
         dr_kind_in  = cmd.dr_kind;
         fin_kind_in = cmd.fin_kind;
         fin_byte_in = cmd.fin_use_byte ? in_byte : 8'h00;
         ext_byte_in = in_byte;
      end else begin
         if (rd_en) begin
            rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            pend_in   = 1'b1;
         end else if (pay_load) begin
            pend_in = 1'b0;
         end
         if (fin_load) begin
            fin_pend_in = 1'b0;
         end
         if (ext_load) begin
            ext_pend_in = 1'b0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cmd.emit_kind;
         rsp_byte_in  = in_byte;
         rsp_last_in  = 1'b1;
      end else if (pay_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = dr_kind_ff;
         rsp_byte_in  = rd_data;
         rsp_last_in  = 1'b0;
      end else if (fin_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = fin_kind_ff;
         rsp_byte_in  = fin_byte_ff;
         rsp_last_in  = !ext_pend_ff;
      end else if (ext_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = EV_ESC_FINAL;
         rsp_byte_in  = ext_byte_ff;
         rsp_last_in  = 1'b1;
      end else begin
         rsp_last_in = rsp_last_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         pend_ff      <= 1'b0;
         fin_pend_ff  <= 1'b0;
         ext_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         pend_ff      <= pend_in;
         fin_pend_ff  <= fin_pend_in;
         ext_pend_ff  <= ext_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dr_kind_ff  <= dr_kind_in;
      fin_kind_ff <= fin_kind_in;
      fin_byte_ff <= fin_byte_in;
      ext_byte_ff <= ext_byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign sts.out_free   = out_free;
   assign sts.count      = count_ff;
   assign sts.drain_done = drain_done;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_event_byte  = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

@@ hdl/terminal_escape_sequence_parser.sv @@
// Terminal escape sequence parser: top level joining controller and datapath.
//
// Input channel req_*: one raw terminal byte per transaction.
// Result channel rsp_*: one event per transaction (kind, byte, last_of_run);
// last_of_run marks the final event caused by an input byte.
// Text, control and escape-final events appear in the output register in the
// cycle after the byte is taken; a byte that does not end a stored sequence can be
// taken every cycle while the receiver keeps up.
// CSI, OSC and DCS payload bytes are stored in a payload RAM of
// max(CSI_CAP, OSC_CAP, DCS_CAP) entries. On a terminator the input is held
// while the store is replayed through its registered read port, followed by
// the close event and, when an escape closes an OSC, an escape-final event.
// Events then leave one per cycle while the receiver keeps up.
// While an event waits in the output register with rsp_ready low, the event
// holds, any drain pauses and req_ready stays low, so nothing is lost or
// repeated.
// Reset returns the parser to ground with an empty payload; the RAM contents
// are not cleared and need no clearing pass.
module terminal_escape_sequence_parser #(
   parameter int CSI_CAP = 32,
   parameter int OSC_CAP = 48,
   parameter int DCS_CAP = 48
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_event_kind,
   output logic [7:0] rsp_event_byte,
   output logic       rsp_last_of_run
);
   import tesp_pkg::*;

   localparam int STORE_DEPTH_A = (CSI_CAP > OSC_CAP) ? CSI_CAP : OSC_CAP;
   localparam int STORE_DEPTH   = (STORE_DEPTH_A > DCS_CAP) ? STORE_DEPTH_A : DCS_CAP;

   tesp_cmd_type cmd;
   tesp_sts_type sts;

   // parse control
   tesp_ctrl #(
      .CSI_CAP (CSI_CAP),
      .OSC_CAP (OSC_CAP),
      .DCS_CAP (DCS_CAP)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .in_byte   (req_in_byte),
      .sts       (sts),
      .cmd       (cmd)
   );

   // payload and output datapath
   tesp_dpath #(
      .DEPTH (STORE_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .in_byte         (req_in_byte),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_byte  (rsp_event_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

`ifndef ASSERT_OFF
   // a terminator blocks further input until its drain has run
   a_drain_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && cmd.drain_start) |=> !req_ready)
      else $error("input taken while payload drain pending");

   // fill count stays within the payload store
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      sts.count <= CNT_W'(STORE_DEPTH))
      else $error("payload count beyond store depth");

   // replayed payload bytes are never the last event of a run
   a_payload_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == EV_CSI_PARAM || rsp_event_kind == EV_OSC_BYTE ||
                     rsp_event_kind == EV_DCS_BYTE)) |-> !rsp_last_of_run)
      else $error("payload event flagged as last of run");

   // completing a drain returns control to the run phase
   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      sts.drain_done |=> !cmd.drain_run)
      else $error("drain still running after completion");
`endif

endmodule

@@ tb/sv/terminal_escape_sequence_parser_checker.sv @@
// Event predictor and scoreboard for the terminal escape sequence parser.
`timescale 1ns / 100ps

module terminal_escape_sequence_parser_checker #(
   parameter int CSI_CAP = 32,
   parameter int OSC_CAP = 48,
   parameter int DCS_CAP = 48
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [3:0] rsp_event_kind,
   input  logic [7:0] rsp_event_byte,
   input  logic       rsp_last_of_run,
   output int         fail_count,
   output int         pending_count,
   output int         checked_count
);
   import tesp_pkg::*;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     event_data;
      logic           last;
   } parser_event_type;

   // Events still owed by the parser, oldest first
   parser_event_type expected_events[$];
   // Events produced by the byte being predicted
   parser_event_type byte_events[$];

   // Shadow parser state
   parse_state_type  shadow_state;
   logic [7:0]       shadow_store [64];
   logic [CNT_W-1:0] shadow_count;

   task automatic report_mismatch(input string msg);
      $display("%0t ns  event mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic add_event(input event_kind_type kind, input logic [7:0] data);
      parser_event_type ev;
      ev.kind       = kind;
      ev.event_data = data;
      ev.last       = 1'b0;
      if (byte_events.size() < 64) byte_events = {byte_events, ev};
   endtask

   task automatic replay_payload(input event_kind_type kind);
      for (int i = 0; i < shadow_count; i++) add_event(kind, shadow_store[i]);
   endtask

   task automatic store_payload(input logic [7:0] b);
      shadow_store[shadow_count] = b;
      shadow_count               = shadow_count + 1'b1;
   endtask

   // Byte that follows an ESC: opens a string sequence or is an escape final
   task automatic follow_escape(input logic [7:0] b);
      shadow_count = '0;
      if (b == BYTE_CSI_INTRO) shadow_state = ST_CSI;
      else if (b == BYTE_OSC_INTRO) shadow_state = ST_OSC;
      else if (b == BYTE_DCS_INTRO) shadow_state = ST_DCS;
      else begin
         add_event(EV_ESC_FINAL, b);
         shadow_state = ST_GROUND;
      end
   endtask

   task automatic predict_events(input logic [7:0] b);
      parser_event_type ev;
      byte_events.delete();
      case (shadow_state)
         ST_ESC: follow_escape(b);
         ST_CSI: begin
            if (b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI) begin
               replay_payload(EV_CSI_PARAM);
               add_event(EV_CSI_FINAL, b);
               shadow_count = '0;
               shadow_state = ST_GROUND;
            end else if (shadow_count >= CSI_CAP) begin
               shadow_count = '0;
               shadow_state = ST_GROUND;
            end else begin
               store_payload(b);
            end
         end
         ST_OSC: begin
            if (b == BYTE_BEL) begin
               replay_payload(EV_OSC_BYTE);
               add_event(EV_OSC_END, 8'h00);
               shadow_count = '0;
               shadow_state = ST_GROUND;
            end else if (b == BYTE_ESC) begin
               shadow_state = ST_OSC_ESC;
            end else if (shadow_count >= OSC_CAP) begin
               shadow_count = '0;
               shadow_state = ST_GROUND;
            end else begin
               store_payload(b);
            end
         end
         // Any byte closes the OSC; only a backslash is swallowed
         ST_OSC_ESC: begin
            replay_payload(EV_OSC_BYTE);
            add_event(EV_OSC_END, 8'h00);
            shadow_count = '0;
            if (b == BYTE_ST_TAIL) shadow_state = ST_GROUND;
            else follow_escape(b);
         end
         ST_DCS: begin
            if (b == BYTE_ESC) begin
               shadow_state = ST_DCS_ESC;
            end else if (b == BYTE_CAN || b == BYTE_SUB) begin
               shadow_count = '0;
               shadow_state = ST_GROUND;
            end else if (shadow_count >= DCS_CAP) begin
               shadow_count = '0;
               shadow_state = ST_DCS_IGN;
            end else begin
               store_payload(b);
            end
         end
         ST_DCS_ESC: begin
            if (b == BYTE_ST_TAIL) begin
               replay_payload(EV_DCS_BYTE);
               add_event(EV_DCS_END, 8'h00);
               shadow_count = '0;
               shadow_state = ST_GROUND;
            end else begin
               shadow_count = '0;
               follow_escape(b);
            end
         end
         ST_DCS_IGN: begin
            if (b == BYTE_ESC) shadow_state = ST_DCS_IGN_ESC;
            else if (b == BYTE_CAN || b == BYTE_SUB) shadow_state = ST_GROUND;
         end
         ST_DCS_IGN_ESC: begin
            if (b == BYTE_ST_TAIL) shadow_state = ST_GROUND;
            else if (b != BYTE_ESC) shadow_state = ST_DCS_IGN;
         end
         default: begin
            if (b == BYTE_ESC) shadow_state = ST_ESC;
            else begin
               add_event((b < BYTE_SPACE) ? EV_CONTROL : EV_TEXT, b);
               shadow_state = ST_GROUND;
            end
         end
      endcase
      // Flag the final event of this byte and queue them all
      foreach (byte_events[i]) begin
         ev      = byte_events[i];
         ev.last = (i == byte_events.size() - 1);
         expected_events = {expected_events, ev};
      end
   endtask

   // Compare each event transaction, then predict from each byte transaction
   always @(posedge clock) begin
      parser_event_type want;
      if (reset) begin
         shadow_state = ST_GROUND;
         shadow_count = '0;
         expected_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event kind %0d byte %02h last %0b",
                                         rsp_event_kind, rsp_event_byte, rsp_last_of_run));
            end else begin
               want = expected_events.pop_front();
               checked_count++;
               if (rsp_event_kind !== want.kind)
                  report_mismatch($sformatf("event_kind %0d, expected %0d",
                                            rsp_event_kind, want.kind));
               if (rsp_event_byte !== want.event_data)
                  report_mismatch($sformatf("event_byte %02h, expected %02h (kind %0d)",
                                            rsp_event_byte, want.event_data, want.kind));
               if (rsp_last_of_run !== want.last)
                  report_mismatch($sformatf("last_of_run %0b, expected %0b (kind %0d)",
                                            rsp_last_of_run, want.last, want.kind));
            end
         end
         if (req_valid && req_ready) predict_events(req_in_byte);
      end
      pending_count = expected_events.size();
   end

endmodule

@@ tb/sv/terminal_escape_sequence_parser_test.sv @@
// Top of the testbench: byte stimulus, flow control, watchdog and verdict.
`timescale 1ns / 100ps

module terminal_escape_sequence_parser_test;
   import tesp_pkg::*;

   localparam int CSI_CAP     = 32;
   localparam int OSC_CAP     = 48;
   localparam int DCS_CAP     = 48;
   localparam int STALL_LIMIT = 4000;  // cycles with no transaction on either channel
   localparam int TAIL_CYCLES = 64;    // longer than the longest drain

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [3:0] rsp_event_kind;
   logic [7:0] rsp_event_byte;
   logic       rsp_last_of_run;

   int fail_count;
   int pending_count;
   int checked_count;
   int req_idle_pct;
   int rsp_idle_pct;
   int bytes_counted;
   int bytes_total;
   int stall_cycles;

   terminal_escape_sequence_parser #(
      .CSI_CAP(CSI_CAP),
      .OSC_CAP(OSC_CAP),
      .DCS_CAP(DCS_CAP)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_event_byte (rsp_event_byte),
      .rsp_last_of_run(rsp_last_of_run)
   );

   terminal_escape_sequence_parser_checker #(
      .CSI_CAP(CSI_CAP),
      .OSC_CAP(OSC_CAP),
      .DCS_CAP(DCS_CAP)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_event_byte (rsp_event_byte),
      .rsp_last_of_run(rsp_last_of_run),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Watchdog: no transaction on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d events outstanding",
                  stall_cycles, pending_count);
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // One byte transaction, with an optional idle gap in front of it
   task automatic drive_byte(input logic [7:0] b, input bit counted);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_total++;
      if (counted) bytes_counted++;
   endtask

   // Random byte other than the four given
   function automatic logic [7:0] rand_byte_avoid(input logic [7:0] x0, input logic [7:0] x1,
                                                  input logic [7:0] x2, input logic [7:0] x3);
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == x0 || b == x1 || b == x2 || b == x3);
      return b;
   endfunction

   // Payload length: mostly short, sometimes exactly full, sometimes one past full
   function automatic int pick_length(input int cap);
      int r;
      r = $urandom_range(99);
      if (r < 8) return cap;
      if (r < 14) return cap + 1;
      return $urandom_range(6);
   endfunction

   task automatic drive_random_sequence();
      int         kind;
      int         n;
      logic [7:0] b;
      kind = $urandom_range(99);
      if (kind < 25) begin
         // plain text and controls
         n = $urandom_range(1, 4);
         repeat (n) drive_byte(rand_byte_avoid(BYTE_ESC, BYTE_ESC, BYTE_ESC, BYTE_ESC), 1);
      end else if (kind < 35) begin
         // two-byte escape
         drive_byte(BYTE_ESC, 1);
         drive_byte(rand_byte_avoid(BYTE_CSI_INTRO, BYTE_OSC_INTRO, BYTE_DCS_INTRO,
                                    BYTE_DCS_INTRO), 1);
      end else if (kind < 55) begin
         // CSI: params outside the final range, then a final byte unless overflowed
         n = pick_length(CSI_CAP);
         drive_byte(BYTE_ESC, 1);
         drive_byte(BYTE_CSI_INTRO, 1);
         repeat (n) begin
            do b = 8'($urandom_range(255)); while (b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI);
            drive_byte(b, 1);
         end
         if (n <= CSI_CAP) drive_byte(8'($urandom_range(BYTE_FINAL_LO, BYTE_FINAL_HI)), 1);
      end else if (kind < 73) begin
         // OSC closed by BEL, by ST, or by ESC and another escape
         n = pick_length(OSC_CAP);
         drive_byte(BYTE_ESC, 1);
         drive_byte(BYTE_OSC_INTRO, 1);
         repeat (n) drive_byte(rand_byte_avoid(BYTE_BEL, BYTE_ESC, BYTE_ESC, BYTE_ESC), 1);
         if (n <= OSC_CAP) begin
            case ($urandom_range(2))
               0: drive_byte(BYTE_BEL, 1);
               1: begin
                  drive_byte(BYTE_ESC, 1);
                  drive_byte(BYTE_ST_TAIL, 1);
               end
               default: begin
                  drive_byte(BYTE_ESC, 1);
                  drive_byte(rand_byte_avoid(BYTE_CSI_INTRO, BYTE_OSC_INTRO, BYTE_DCS_INTRO,
                                             BYTE_ST_TAIL), 1);
               end
            endcase
         end
      end else if (kind < 91) begin
         // DCS closed by ST, cancelled, or dropped by another escape
         n = pick_length(DCS_CAP);
         drive_byte(BYTE_ESC, 1);
         drive_byte(BYTE_DCS_INTRO, 1);
         repeat (n) drive_byte(rand_byte_avoid(BYTE_ESC, BYTE_CAN, BYTE_SUB, BYTE_SUB), 1);
         if (n <= DCS_CAP) begin
            case ($urandom_range(4))
               0, 1: begin
                  drive_byte(BYTE_ESC, 1);
                  drive_byte(BYTE_ST_TAIL, 1);
               end
               2: drive_byte(BYTE_CAN, 1);
               3: drive_byte(BYTE_SUB, 1);
               default: begin
                  drive_byte(BYTE_ESC, 1);
                  drive_byte(rand_byte_avoid(BYTE_CSI_INTRO, BYTE_OSC_INTRO, BYTE_DCS_INTRO,
                                             BYTE_ST_TAIL), 1);
               end
            endcase
         end else begin
            // overflowed: ignore mode until CAN, SUB or ST
            repeat ($urandom_range(1, 3))
               drive_byte(rand_byte_avoid(BYTE_ESC, BYTE_CAN, BYTE_SUB, BYTE_SUB), 0);
            if ($urandom_range(1)) begin
               drive_byte(BYTE_ESC, 0);
               drive_byte(BYTE_ESC, 0);
               drive_byte(rand_byte_avoid(BYTE_ST_TAIL, BYTE_ESC, BYTE_ESC, BYTE_ESC), 0);
            end
            case ($urandom_range(2))
               0: drive_byte(BYTE_CAN, 1);
               1: drive_byte(BYTE_SUB, 1);
               default: begin
                  drive_byte(BYTE_ESC, 1);
                  drive_byte(BYTE_ST_TAIL, 1);
               end
            endcase
         end
      end else begin
         // noise
         repeat ($urandom_range(1, 3)) drive_byte(8'($urandom_range(255)), 1);
      end
   endtask

   initial begin
      logic [7:0] directed_bytes[$];
      int         phase_goal;

      directed_bytes = '{
         8'h00, 8'hFF, 8'h7F, 8'h80,
         BYTE_ESC, 8'h63,
         BYTE_ESC, BYTE_CSI_INTRO, 8'h31, BYTE_ESC, 8'h6D,
         BYTE_ESC, BYTE_OSC_INTRO, 8'h30, BYTE_BEL,
         BYTE_ESC, BYTE_OSC_INTRO, 8'h61, BYTE_ESC, BYTE_CSI_INTRO, BYTE_FINAL_LO,
         BYTE_ESC, BYTE_DCS_INTRO, 8'h71, BYTE_ESC, BYTE_ST_TAIL,
         BYTE_ESC, BYTE_DCS_INTRO, 8'h62, BYTE_CAN,
         BYTE_ESC, BYTE_DCS_INTRO, BYTE_ESC, 8'h63
      };

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_byte   = 8'h00;
      req_idle_pct  = 37;
      rsp_idle_pct  = 54;
      bytes_counted = 0;
      bytes_total   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every event kind, BEL, ST and escape closes, a CAN cancel
      foreach (directed_bytes[i]) drive_byte(directed_bytes[i], 1);

      // Random: three flow-control mixes
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 37;
               rsp_idle_pct = 54;
            end
            1: begin
               req_idle_pct = 54;
               rsp_idle_pct = 37;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         phase_goal = bytes_counted + 45;
         while (bytes_counted < phase_goal) drive_random_sequence();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Drove %0d bytes (%0d outside DCS ignore mode): escapes, CSI/OSC/DCS runs,",
               bytes_total, bytes_counted);
      $display("buffer overflows and cancels under three flow-control mixes; %0d events checked",
               checked_count);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
